### rtl/core/clle_pkg.sv
// clle_pkg: shared constants and types for the cursor linked list engine
// no dependencies
`timescale 1ns / 1ps
package clle_pkg;
    localparam int CELLS = 16;
    localparam int PW = $clog2(CELLS + 1);
    localparam int IW = $clog2(CELLS);
    localparam logic [PW-1:0] NIL = PW'(CELLS);

    localparam logic [2:0] MODE_INS_HEAD = 3'd0;
    localparam logic [2:0] MODE_INS_TAIL = 3'd1;
    localparam logic [2:0] MODE_INS_SORT = 3'd2;
    localparam logic [2:0] MODE_DEL_FIRST = 3'd3;
    localparam logic [2:0] MODE_DEL_ALL = 3'd4;
    localparam logic [2:0] MODE_DUMP = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [2:0] mode;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] removed_count;
        logic [31:0] item_value;
        logic item_valid;
        logic last;
    } t_res;
endpackage

### rtl/core/clle_front.sv
// clle_front: input transfer stage and command queue
// depends on clle_pkg
`timescale 1ns / 1ps
module clle_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  clle_pkg::t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output clle_pkg::t_cmd o_cmd
);
    clle_pkg::t_cmd r_q [clle_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'(clle_pkg::QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

### rtl/core/clle_back.sv
// clle_back: list walker over the cell pool, executes one command at a time
// depends on clle_pkg
`timescale 1ns / 1ps
module clle_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  clle_pkg::t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output clle_pkg::t_res o_res
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_OUT = 3'd3;
    localparam logic [2:0] S_DUMP = 3'd4;

    localparam int PW = clle_pkg::PW;
    localparam int IW = clle_pkg::IW;
    localparam logic [PW-1:0] NIL = clle_pkg::NIL;

    logic [31:0] r_val [clle_pkg::CELLS];
    logic [PW-1:0] r_link [clle_pkg::CELLS];
    logic [PW-1:0] r_head, r_free, r_cur, r_prev, r_newc;
    logic [2:0] r_st, r_mode;
    logic [31:0] r_v;
    logic [PW-1:0] r_n;
    logic [4:0] r_rm;
    logic r_ov;
    clle_pkg::t_res r_res;

    logic w_curc, w_nxtc, w_less, w_full;
    logic [PW-1:0] w_nxt;
    logic [31:0] w_cv, w_nv;

    function automatic logic isc(input logic [PW-1:0] p);
        return p < NIL;
    endfunction

    assign w_curc = isc(r_cur);
    assign w_nxt = w_curc ? r_link[r_cur[IW-1:0]] : NIL;
    assign w_nxtc = isc(w_nxt);
    assign w_cv = r_val[r_cur[IW-1:0]];
    assign w_nv = r_val[w_nxt[IW-1:0]];
    assign w_less = $signed(w_nv) < $signed(r_v);
    assign w_full = (r_mode <= clle_pkg::MODE_INS_SORT) && !isc(r_free);

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_head <= NIL;
            r_free <= '0;
            for (int i = 0; i < clle_pkg::CELLS; i++) r_link[i] <= PW'(i + 1);
        end else begin
            if (r_ov && i_ready && r_st != S_DUMP) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_mode <= i_cmd.mode;
                        r_v <= i_cmd.value;
                        r_cur <= r_head;
                        r_prev <= NIL;
                        r_n <= '0;
                        r_rm <= '0;
                        r_st <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_res <= '{status: w_full ? clle_pkg::ST_FULL : clle_pkg::ST_OK,
                               removed_count: 5'd0,
                               item_value: 32'd0, item_valid: 1'b0, last: 1'b1};
                    if (r_mode <= clle_pkg::MODE_INS_SORT) begin
                        if (w_full) begin
                            r_st <= S_OUT;
                        end else begin
                            r_newc <= r_free;
                            r_free <= r_link[r_free[IW-1:0]];
                            r_val[r_free[IW-1:0]] <= r_v;
                            if (r_mode == clle_pkg::MODE_INS_HEAD || !w_curc ||
                                (r_mode == clle_pkg::MODE_INS_SORT &&
                                 !($signed(w_cv) < $signed(r_v)))) begin
                                r_link[r_free[IW-1:0]] <= r_head;
                                r_head <= r_free;
                                r_st <= S_OUT;
                            end else begin
                                r_st <= S_WALK;
                            end
                        end
                    end else if (r_mode == clle_pkg::MODE_DEL_FIRST ||
                                 r_mode == clle_pkg::MODE_DEL_ALL) begin
                        r_st <= S_WALK;
                    end else if (r_mode == clle_pkg::MODE_DUMP && w_curc) begin
                        r_st <= S_DUMP;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_WALK: begin
                    if (r_mode <= clle_pkg::MODE_INS_SORT) begin
                        if (w_nxtc && r_n != NIL &&
                            (r_mode == clle_pkg::MODE_INS_TAIL || w_less)) begin
                            r_cur <= w_nxt;
                            r_n <= r_n + 1'b1;
                        end else begin
                            r_link[r_newc[IW-1:0]] <= w_nxt;
                            r_link[r_cur[IW-1:0]] <= r_newc;
                            r_st <= S_OUT;
                        end
                    end else begin
                        if (w_curc && r_n != NIL) begin
                            r_n <= r_n + 1'b1;
                            if (w_cv == r_v) begin
                                if (isc(r_prev)) r_link[r_prev[IW-1:0]] <= w_nxt;
                                else r_head <= w_nxt;
                                r_link[r_cur[IW-1:0]] <= r_free;
                                r_free <= r_cur;
                                r_rm <= r_rm + 1'b1;
                                r_cur <= w_nxt;
                                if (r_mode == clle_pkg::MODE_DEL_FIRST) begin
                                    r_res.removed_count <= r_rm + 1'b1;
                                    r_st <= S_OUT;
                                end
                            end else begin
                                r_prev <= r_cur;
                                r_cur <= w_nxt;
                            end
                        end else begin
                            r_res.removed_count <= r_rm;
                            if (r_rm == 5'd0) r_res.status <= clle_pkg::ST_NOT_FOUND;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (!r_ov || i_ready) begin
                        r_ov <= 1'b1;
                        r_res <= '{status: clle_pkg::ST_OK, removed_count: 5'd0,
                                   item_value: w_cv, item_valid: 1'b1,
                                   last: !w_nxtc || (r_n == NIL - 1'b1)};
                        r_cur <= w_nxt;
                        r_n <= r_n + 1'b1;
                        if (!w_nxtc || r_n == NIL - 1'b1) r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/cursor_linked_list_engine.sv
// cursor_linked_list_engine: top level, command queue feeding the list walker
// depends on clle_pkg, clle_front, clle_back
// throughput: one command at a time, the next starts once the previous result is taken;
// one cell visited per cycle; dump one transfer per cycle while m_axis_tready is high
// reset: synchronous active low, empty list, all cells on the free list
`timescale 1ns / 1ps
module cursor_linked_list_engine (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [39:0] s_axis_tdata, // mode[2:0], value[34:3], zero pad
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [39:0] m_axis_tdata, // status[1:0], removed_count[6:2], item_value[38:7], pad
    output logic m_axis_tuser, // item_valid
    output logic m_axis_tlast
);
    clle_pkg::t_cmd w_in, w_q;
    clle_pkg::t_res w_res;
    logic w_qv, w_qr;

    assign w_in.mode = s_axis_tdata[2:0];
    assign w_in.value = s_axis_tdata[34:3];

    clle_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_q)
    );

    clle_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {1'b0, w_res.item_value, w_res.removed_count, w_res.status};
    assign m_axis_tuser = w_res.item_valid;
    assign m_axis_tlast = w_res.last;
endmodule

### rtl/core/clle_checker.sv
// clle_checker: port level checks for the engine
// depends on cursor_linked_list_engine ports
`timescale 1ns / 1ps
module clle_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic m_axis_tuser,
    input logic m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_novld_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("non item result not last");
    a_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[6:0] == 7'd0)
        else $error("dump item with status");
    a_noitem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[38:7] == 32'd0)
        else $error("nonzero value without item");
endmodule

bind cursor_linked_list_engine clle_checker u_clle_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
